// ----- rtl/lcl_pkg.sv -----
// shared codes and types for the line and column locator
package lcl_pkg;

  localparam logic [1:0] FUNC_BYTE  = 2'd0;
  localparam logic [1:0] FUNC_QUERY = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  localparam logic [7:0] NEWLINE_BYTE = 8'd10;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    OP_BYTE,
    OP_QUERY,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t  op;
    logic newline;
  } req_ctl_t;

endpackage

// ----- rtl/line_column_locator.sv -----
// top level of the line and column locator
//
// input side is a queue: a request is taken when push is high and full is low.
// func selects a text byte, a position query or a clear that starts a new text.
// text bytes are counted from zero; each newline records the next position as
// a line start, up to MAX_LINES lines, after which newlines set table_overflow.
// result side holds one result: a query result shows while empty is low and is taken
// when pop is high; bytes and clears give no result.
// requests pass a 4-deep request queue, then the back end takes one per cycle
// while it is not busy with a query. a query runs a binary search over the line
// table with one table read per step, for at most floor(log2(lines))+1 steps; each
// step has an address state and a compare state, since the table memory read
// port is registered.
// if the receiver does not pop, one result is held and the back end waits at
// the next finished query; the request queue then fills and full goes high.
// reset (synchronous) leaves one line starting at 0, no overflow,
// empty queues; no clearing pass is needed.
module line_column_locator import lcl_pkg::*; #(
  parameter int MAX_LINES = 1024,
  parameter int POS_BITS  = 24
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic [1:0]                     func,
  input  logic [7:0]                     text_byte,
  input  logic [POS_BITS-1:0]            query_pos,
  output logic                           empty,
  input  logic                           pop,
  output logic [$clog2(MAX_LINES+1)-1:0] line_number,
  output logic [POS_BITS:0]              column_number,
  output logic                           table_overflow
);

  logic                req_valid;
  req_ctl_t            req_ctl;
  logic [POS_BITS-1:0] req_pos;
  logic                req_pop;

  lcl_front #(
    .POS_BITS (POS_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .func      (func),
    .text_byte (text_byte),
    .query_pos (query_pos),
    .req_valid (req_valid),
    .req_ctl   (req_ctl),
    .req_pos   (req_pos),
    .req_pop   (req_pop)
  );

  lcl_back #(
    .MAX_LINES (MAX_LINES),
    .POS_BITS  (POS_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_ctl        (req_ctl),
    .req_pos        (req_pos),
    .req_pop        (req_pop),
    .empty          (empty),
    .pop            (pop),
    .line_number    (line_number),
    .column_number  (column_number),
    .table_overflow (table_overflow)
  );

endmodule

// ----- rtl/lcl_front.sv -----
// front end: decodes incoming requests and queues them for the back end
module lcl_front import lcl_pkg::*; #(
  parameter int POS_BITS = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [1:0]          func,
  input  logic [7:0]          text_byte,
  input  logic [POS_BITS-1:0] query_pos,
  output logic                req_valid,
  output req_ctl_t            req_ctl,
  output logic [POS_BITS-1:0] req_pos,
  input  logic                req_pop
);

  localparam logic [QPTR_W:0] QFULL = (QPTR_W+1)'(QDEPTH);

  req_ctl_t            q_ctl [QDEPTH];
  logic [POS_BITS-1:0] q_pos [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QPTR_W:0]     count;
  req_ctl_t            ctl_in;
  logic                store;
  logic                wr;
  logic                rd;

  always_comb begin
    ctl_in.newline = (text_byte == NEWLINE_BYTE);
    store          = 1'b1;
    unique case (func)
      FUNC_BYTE:  ctl_in.op = OP_BYTE;
      FUNC_QUERY: ctl_in.op = OP_QUERY;
      FUNC_CLEAR: ctl_in.op = OP_CLEAR;
      default: begin
        // unused code: taken and dropped
        ctl_in.op = OP_BYTE;
        store     = 1'b0;
      end
    endcase
  end

  assign full      = (count == QFULL);
  assign req_valid = (count != '0);
  assign req_ctl   = q_ctl[rd_ptr];
  assign req_pos   = q_pos[rd_ptr];
  assign wr        = push && !full && store;
  assign rd        = req_pop && req_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        q_ctl[wr_ptr] <= ctl_in;
        q_pos[wr_ptr] <= query_pos;
        wr_ptr        <= wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + {{QPTR_W{1'b0}}, wr} - {{QPTR_W{1'b0}}, rd};
    end
  end

endmodule

// ----- rtl/lcl_back.sv -----
// back end: line table, byte counter and binary search over the table
module lcl_back import lcl_pkg::*; #(
  parameter int MAX_LINES = 1024,
  parameter int POS_BITS  = 24
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 req_valid,
  input  req_ctl_t                             req_ctl,
  input  logic [POS_BITS-1:0]                  req_pos,
  output logic                                 req_pop,
  output logic                                 empty,
  input  logic                                 pop,
  output logic [$clog2(MAX_LINES+1)-1:0]       line_number,
  output logic [POS_BITS:0]                    column_number,
  output logic                                 table_overflow
);

  localparam int IDX_W = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int CNT_W = $clog2(MAX_LINES+1);
  localparam logic [CNT_W-1:0] LINES_MAX = CNT_W'(MAX_LINES);
  localparam logic [CNT_W-1:0] ONE_LINE  = CNT_W'(1);

  typedef enum logic [1:0] {
    S_FETCH,
    S_ADDR,
    S_CMP,
    S_OUT
  } state_t;

  state_t              state;
  logic [POS_BITS-1:0] line_starts [MAX_LINES];
  logic [CNT_W-1:0]    lines_used;
  logic [POS_BITS-1:0] byte_counter;
  logic                overflow;
  logic [CNT_W-1:0]    lo;
  logic [CNT_W-1:0]    hi;
  logic [CNT_W-1:0]    mid_q;
  logic [POS_BITS-1:0] pos_q;
  logic [POS_BITS-1:0] best_start;
  logic [POS_BITS-1:0] rd_data;
  logic                rd_zero;
  logic                out_valid;

  logic [CNT_W-1:0]    mid;
  logic [POS_BITS-1:0] byte_next;
  logic [POS_BITS-1:0] rd_start;
  logic                room;
  logic                wr_en;
  logic                out_free;
  logic                out_load;

  assign mid       = lo + ((hi - lo) >> 1);
  // saturating count; also the start of the line after a newline
  assign byte_next = (byte_counter == '1) ? byte_counter : byte_counter + 1'b1;
  assign room      = (lines_used < LINES_MAX);
  assign req_pop   = (state == S_FETCH) && req_valid;
  assign wr_en     = req_pop && (req_ctl.op == OP_BYTE) && req_ctl.newline && room;
  // entry 0 is never stored, it always reads as zero
  assign rd_start  = rd_zero ? '0 : rd_data;
  assign out_free  = !out_valid || pop;
  assign out_load  = (state == S_OUT) && out_free;
  assign empty     = !out_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_starts[lines_used[IDX_W-1:0]] <= byte_next;
    end
    rd_data <= line_starts[mid[IDX_W-1:0]];
    rd_zero <= (mid == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_FETCH;
      lines_used   <= ONE_LINE;
      byte_counter <= '0;
      overflow     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_FETCH: begin
          if (req_valid) begin
            unique case (req_ctl.op)
              OP_BYTE: begin
                byte_counter <= byte_next;
                if (req_ctl.newline) begin
                  if (room) begin
                    lines_used <= lines_used + 1'b1;
                  end else begin
                    overflow <= 1'b1;
                  end
                end
              end
              OP_QUERY: begin
                lo         <= '0;
                hi         <= lines_used;
                pos_q      <= req_pos;
                best_start <= '0;
                state      <= S_ADDR;
              end
              OP_CLEAR: begin
                lines_used   <= ONE_LINE;
                byte_counter <= '0;
                overflow     <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        S_ADDR: begin
          if (lo < hi) begin
            mid_q <= mid;
            state <= S_CMP;
          end else begin
            state <= S_OUT;
          end
        end
        S_CMP: begin
          if (rd_start <= pos_q) begin
            lo         <= mid_q + 1'b1;
            best_start <= rd_start;
          end else begin
            hi <= mid_q;
          end
          state <= S_ADDR;
        end
        S_OUT: begin
          if (out_load) begin
            line_number    <= (lo == '0) ? ONE_LINE : lo;
            column_number  <= {1'b0, pos_q} - {1'b0, best_start} + 1'b1;
            table_overflow <= overflow;
            state          <= S_FETCH;
          end
        end
        default: state <= S_FETCH;
      endcase
    end
  end

endmodule

// ----- rtl/lcl_checker.sv -----
// port-level checks for the line and column locator, bound to the top level
module lcl_checker #(
  parameter int MAX_LINES = 1024,
  parameter int POS_BITS  = 24
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           full,
  input logic                           empty,
  input logic                           pop,
  input logic [$clog2(MAX_LINES+1)-1:0] line_number,
  input logic [POS_BITS:0]              column_number,
  input logic                           table_overflow
);

  // reset drops any waiting result and empties the request queue
  a_rst_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result pending after reset");

  a_rst_full: assert property (@(posedge clk) rst |=> !full)
    else $error("request queue full after reset");

  // a result not taken holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(line_number) && $stable(column_number)
                          && $stable(table_overflow)))
    else $error("waiting result changed");

  a_line_nz: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (line_number != '0))
    else $error("line number zero");

  a_col_nz: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (column_number != '0))
    else $error("column number zero");

endmodule

bind line_column_locator lcl_checker #(
  .MAX_LINES (MAX_LINES),
  .POS_BITS  (POS_BITS)
) u_lcl_checker (.*);

// ----- sim/testbench.sv -----
// testbench for the line and column locator: random texts and queries against a predictor
`timescale 1ns / 100ps

module testbench;
  import lcl_pkg::*;

  localparam int MAX_LINES = 1024;
  localparam int POS_BITS  = 24;
  localparam int LINE_W    = $clog2(MAX_LINES + 1);
  localparam logic [1:0] FUNC_SPARE = 2'd3;
  localparam logic [POS_BITS-1:0] POS_MAX = '1;

  typedef struct {
    logic [1:0]          func;
    logic [7:0]          text_byte;
    logic [POS_BITS-1:0] query_pos;
  } text_req_t;

  typedef struct {
    logic [LINE_W-1:0] line_number;
    logic [POS_BITS:0] column_number;
    logic              table_overflow;
  } location_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                push = 1'b0;
  logic                full;
  logic [1:0]          func = FUNC_BYTE;
  logic [7:0]          text_byte = '0;
  logic [POS_BITS-1:0] query_pos = '0;
  logic                empty;
  logic                pop = 1'b0;
  logic [LINE_W-1:0]   line_number;
  logic [POS_BITS:0]   column_number;
  logic                table_overflow;

  text_req_t pending_requests[$];
  location_t expected_locations[$];
  text_req_t next_req;
  bit        req_taken = 1'b0;
  int        sender_idle_pct = 0;
  int        receiver_idle_pct = 0;
  bit        hold_request = 1'b0;
  bit        hold_done = 1'b0;
  int        hold_left = 0;
  int        mismatches = 0;

  // predictor state
  logic [POS_BITS-1:0] start_table[MAX_LINES] = '{default: '0};
  int                  lines_recorded = 1;
  logic [POS_BITS-1:0] text_offset = '0;
  logic                dropped_newline = 1'b0;

  // generator's own view of the text, used to aim queries
  int gen_pos = 0;
  int gen_starts[$] = '{0};
  int gen_items = 0;

  line_column_locator #(
    .MAX_LINES(MAX_LINES),
    .POS_BITS(POS_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .func(func),
    .text_byte(text_byte),
    .query_pos(query_pos),
    .empty(empty),
    .pop(pop),
    .line_number(line_number),
    .column_number(column_number),
    .table_overflow(table_overflow)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic location_t locate_position(logic [POS_BITS-1:0] pos);
    int lo;
    int hi;
    int mid;
    int idx;
    location_t loc;
    lo = 0;
    hi = lines_recorded;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (start_table[mid] <= pos) lo = mid + 1;
      else hi = mid;
    end
    idx = (lo > 0) ? lo - 1 : 0;
    loc.line_number = LINE_W'(idx + 1);
    if (pos >= start_table[idx])
      loc.column_number = {1'b0, pos} - {1'b0, start_table[idx]} + 1'b1;
    else
      loc.column_number = (POS_BITS+1)'(1);
    loc.table_overflow = dropped_newline;
    return loc;
  endfunction

  task automatic track_request(logic [1:0] f, logic [7:0] b, logic [POS_BITS-1:0] p);
    logic [POS_BITS-1:0] next_start;
    case (f)
      FUNC_BYTE: begin
        if (b == NEWLINE_BYTE) begin
          next_start = (text_offset == POS_MAX) ? POS_MAX : text_offset + 1'b1;
          if (lines_recorded < MAX_LINES) begin
            start_table[lines_recorded] = next_start;
            lines_recorded++;
          end else begin
            dropped_newline = 1'b1;
          end
        end
        if (text_offset != POS_MAX) text_offset++;
      end
      FUNC_QUERY: expected_locations.push_back(locate_position(p));
      FUNC_CLEAR: begin
        start_table[0] = '0;
        lines_recorded = 1;
        text_offset = '0;
        dropped_newline = 1'b0;
      end
      default: ;
    endcase
  endtask

  task automatic add_request(logic [1:0] f, logic [7:0] b, logic [POS_BITS-1:0] p);
    text_req_t r;
    r.func = f;
    r.text_byte = b;
    r.query_pos = p;
    pending_requests.push_back(r);
    case (f)
      FUNC_BYTE: begin
        if (b == NEWLINE_BYTE) gen_starts.push_back(gen_pos + 1);
        gen_pos++;
        gen_items++;
      end
      FUNC_QUERY: gen_items++;
      FUNC_CLEAR: begin
        gen_pos = 0;
        gen_starts.delete();
        gen_starts.push_back(0);
        gen_items++;
      end
      default: ;
    endcase
  endtask

  function automatic logic [POS_BITS-1:0] query_target();
    int r;
    int s;
    r = $urandom_range(99);
    if (r < 40) begin
      // around a line start, one either side
      s = gen_starts[$urandom_range(gen_starts.size() - 1)];
      return POS_BITS'(s + $urandom_range(2) - 1);
    end else if (r < 75) begin
      return POS_BITS'($urandom_range(gen_pos));
    end else if (r < 90) begin
      return POS_BITS'(gen_pos + $urandom_range(20));
    end
    return POS_BITS'($urandom);
  endfunction

  task automatic add_text();
    int len;
    int nl_pct;
    int r;
    if ($urandom_range(3) != 0) add_request(FUNC_CLEAR, 8'($urandom), POS_BITS'($urandom));
    len = $urandom_range(60, 10);
    nl_pct = $urandom_range(40, 2);
    repeat (len) begin
      r = $urandom_range(99);
      if (r < 25)
        add_request(FUNC_QUERY, 8'($urandom), query_target());
      else if (r < 27)
        add_request(FUNC_SPARE, 8'($urandom), POS_BITS'($urandom));
      else if ($urandom_range(99) < nl_pct)
        add_request(FUNC_BYTE, NEWLINE_BYTE, POS_BITS'($urandom));
      else
        add_request(FUNC_BYTE, 8'($urandom), POS_BITS'($urandom));
    end
  endtask

  task automatic wait_drained();
    while (pending_requests.size() != 0 || push || expected_locations.size() != 0)
      @(posedge clk);
  endtask

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (!push || req_taken) begin
      req_taken = 1'b0;
      if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        next_req = pending_requests.pop_front();
        func <= next_req.func;
        text_byte <= next_req.text_byte;
        query_pos <= next_req.query_pos;
        push <= 1'b1;
      end else begin
        push <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && push && !full) begin
      track_request(func, text_byte, query_pos);
      req_taken = 1'b1;
    end
  end

  // result side, with one long hold-off to back up the block
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (hold_request && !hold_done) begin
        hold_left = 400;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= receiver_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    location_t exp_loc;
    if (!rst && pop && !empty) begin
      if (expected_locations.size() == 0) begin
        $error("result with no query waiting: line %0d column %0d", line_number,
               column_number);
        mismatches++;
      end else begin
        exp_loc = expected_locations.pop_front();
        if (line_number !== exp_loc.line_number) begin
          $error("line_number: expected %0d, got %0d", exp_loc.line_number, line_number);
          mismatches++;
        end
        if (column_number !== exp_loc.column_number) begin
          $error("column_number: expected %0d, got %0d", exp_loc.column_number,
                 column_number);
          mismatches++;
        end
        if (table_overflow !== exp_loc.table_overflow) begin
          $error("table_overflow: expected %0d, got %0d", exp_loc.table_overflow,
                 table_overflow);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int target;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    sender_idle_pct = 18;
    receiver_idle_pct = 60;
    add_request(FUNC_QUERY, 8'hFF, '0);
    add_request(FUNC_QUERY, 8'h00, POS_MAX);
    add_request(FUNC_BYTE, 8'h00, POS_MAX);
    add_request(FUNC_BYTE, 8'hFF, '0);
    add_request(FUNC_BYTE, NEWLINE_BYTE, '0);
    add_request(FUNC_BYTE, 8'h61, '0);
    add_request(FUNC_BYTE, NEWLINE_BYTE, '0);
    // empty line
    add_request(FUNC_BYTE, NEWLINE_BYTE, '0);
    add_request(FUNC_BYTE, 8'hAA, '0);
    add_request(FUNC_BYTE, 8'h55, '0);
    add_request(FUNC_QUERY, 8'h00, 24'd2);
    add_request(FUNC_QUERY, 8'h00, 24'd3);
    add_request(FUNC_QUERY, 8'h00, 24'd4);
    add_request(FUNC_QUERY, 8'h00, 24'd5);
    add_request(FUNC_QUERY, 8'h00, 24'd6);
    add_request(FUNC_QUERY, 8'h00, 24'd9);
    add_request(FUNC_QUERY, 8'h00, POS_MAX);
    // spare code must leave the state alone
    add_request(FUNC_SPARE, NEWLINE_BYTE, 24'd1);
    add_request(FUNC_QUERY, 8'h00, 24'd7);
    add_request(FUNC_CLEAR, 8'h00, '0);
    add_request(FUNC_QUERY, 8'h00, 24'd5);
    add_request(FUNC_BYTE, NEWLINE_BYTE, '0);
    add_request(FUNC_QUERY, 8'h00, 24'd0);
    add_request(FUNC_QUERY, 8'h00, 24'd1);
    target = gen_items + 300;
    while (gen_items < target) add_text();
    wait_drained();

    // newline-heavy text that runs past the end of the line table
    sender_idle_pct = 60;
    receiver_idle_pct = 18;
    add_request(FUNC_CLEAR, 8'($urandom), POS_BITS'($urandom));
    while (gen_starts.size() <= MAX_LINES + 5) begin
      if ($urandom_range(99) < 8)
        add_request(FUNC_QUERY, 8'($urandom), query_target());
      else if ($urandom_range(99) < 92)
        add_request(FUNC_BYTE, NEWLINE_BYTE, POS_BITS'($urandom));
      else
        add_request(FUNC_BYTE, 8'($urandom), POS_BITS'($urandom));
    end
    repeat (20) add_request(FUNC_QUERY, 8'($urandom), query_target());
    wait_drained();

    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    hold_request = 1'b1;
    target = gen_items + 350;
    while (gen_items < target) add_text();
    wait_drained();

    repeat (40) @(posedge clk);
    if (mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #5000000;
    $display("simulation failed");
    $finish;
  end

endmodule
